// ===== rtl/pll_divider_search_core_assert.svh =====
// Assertion macros shared by the PLL divider search RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH

// Condition in one cycle implies a condition in the same cycle.
`define PDS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Condition in one cycle implies a condition in the following cycle.
`define PDS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/pds_pkg.sv =====
// Package for the PLL divider search: widths, register codes, reset values,
// and the divider control structs. No dependencies.
package pds_pkg;

  localparam int EXT_W      = 25;
  localparam int TGT_W      = 30;
  localparam int VCO_W      = 30;
  localparam int PREDIV_W   = 6;
  localparam int MHALF_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int DIV_W      = 30;
  localparam int DIV_CNT_W  = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RC_OSC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRE = 2'd3;

  localparam logic [EXT_W-1:0]    RC_OSC_RST  = 25'd4000000;
  localparam logic [VCO_W-1:0]    VCO_MIN_RST = 30'd275000000;
  localparam logic [VCO_W-1:0]    VCO_MAX_RST = 30'd550000000;
  localparam logic [PREDIV_W-1:0] MAX_PRE_RST = 6'd32;

  localparam logic [EXT_W-1:0]    RANGE_HIGH_HZ = 25'd15000000;
  localparam logic [PREDIV_W-1:0] PREDIV_CAP    = 6'd32;
  localparam logic [MHALF_W-1:0]  MHALF_CAP     = 16'd32768;
  localparam logic [DIV_W-1:0]    POSTDIV_CAP   = 30'd256;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } pds_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } pds_div_rsp_t;

endpackage

// ===== rtl/pds_if.sv =====
// Handshake interfaces for the request, result and configuration channels.
// Depends on pds_pkg for field widths.
interface pds_req_if import pds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EXT_W-1:0] ext_hz;
  logic [TGT_W-1:0] target_hz;
  modport source (output valid, ext_hz, target_hz, input ready);
  modport sink (input valid, ext_hz, target_hz, output ready);
endinterface

interface pds_rsp_if ();
  logic        valid;
  logic        ready;
  logic        found;
  logic        use_main_osc;
  logic        osc_range_high;
  logic [4:0]  prediv_code;
  logic [14:0] mult_code;
  logic [7:0]  cpu_div_code;
  modport source (output valid, found, use_main_osc, osc_range_high, prediv_code,
                  mult_code, cpu_div_code, input ready);
  modport sink (input valid, found, use_main_osc, osc_range_high, prediv_code,
                mult_code, cpu_div_code, output ready);
endinterface

interface pds_cfg_if import pds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pll_divider_search_core.sv =====
// Top level of the PLL divider search: configuration registers, search sequencer
// and result register. Depends on pds_pkg, the pds interfaces, pds_div and the macros.
//
// Usage: the block takes one request (ext_hz, target_hz) on the req channel and
// returns one result on the rsp channel. An ext_hz of zero selects the internal RC
// frequency held in configuration register 0. Registers 1 and 2 set the VCO window
// and register 3 the largest pre-divider; the cfg channel is always ready and a
// write takes effect at the transfer. Configuration should only change while idle.
// A request is taken only while the sequencer is idle. For each pre-divider the
// shared divider computes base / P, then the multiplier advances by two each cycle
// while the VCO is below the window, adding twice the quotient to the VCO. Every VCO
// inside the window costs its scan step plus a trip through the same divider to
// test for an exact post-divider. The worst case is a tiny base in a wide window,
// where all 32768 multipliers of each of 32 pre-dividers take a divider trip. The
// result sits in an output register; if the receiver stalls, a following search
// may still run but waits at its end until the register is taken. Reset returns
// all configuration registers to their defaults, empties the result register and
// puts the sequencer in idle.
`include "pll_divider_search_core_assert.svh"

module pll_divider_search_core import pds_pkg::*; (
  input logic         clk,
  input logic         rst,
  pds_cfg_if.sink     cfg,
  pds_req_if.sink     req,
  pds_rsp_if.source   rsp
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START_Q = 3'd1;
  localparam logic [2:0] S_WAIT_Q  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_START_T = 3'd4;
  localparam logic [2:0] S_WAIT_T  = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  // Configuration registers.
  logic [EXT_W-1:0]    rc_osc_hz;
  logic [VCO_W-1:0]    vco_min_hz;
  logic [VCO_W-1:0]    vco_max_hz;
  logic [PREDIV_W-1:0] max_prediv;

  // Search state.
  logic [2:0]          state;
  logic [EXT_W-1:0]    ext;
  logic [TGT_W-1:0]    target;
  logic [EXT_W-1:0]    base;
  logic [PREDIV_W-1:0] lim;
  logic [PREDIV_W-1:0] prediv;
  logic [EXT_W-1:0]    q;
  logic [VCO_W:0]      vco;
  logic [MHALF_W-1:0]  mhalf;
  logic                hit;
  logic [7:0]          div_code;

  // Result register.
  logic        out_valid;
  logic        out_found;
  logic        out_main;
  logic        out_high;
  logic [4:0]  out_prediv;
  logic [14:0] out_mult;
  logic [7:0]  out_div;

  pds_div_req_t dreq;
  pds_div_rsp_t drsp;

  logic          req_xfer;
  logic          out_free;
  logic [VCO_W:0] vco_step;
  logic          mult_last;
  logic          exact;

  pds_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  // Each multiplier step of two adds twice the divided base to the VCO.
  assign vco_step  = vco + {{(VCO_W - EXT_W){1'b0}}, q, 1'b0};
  assign mult_last = (mhalf == MHALF_CAP);
  assign exact     = (drsp.quotient != '0) && (drsp.remainder == '0);

  always_comb begin
    dreq.start    = (state == S_START_Q) || (state == S_START_T);
    dreq.dividend = (state == S_START_Q) ? {{(DIV_W - EXT_W){1'b0}}, base}
                                         : vco[VCO_W-1:0];
    dreq.divisor  = (state == S_START_Q) ? {{(DIV_W - PREDIV_W){1'b0}}, prediv}
                                         : target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_osc_hz  <= RC_OSC_RST;
      vco_min_hz <= VCO_MIN_RST;
      vco_max_hz <= VCO_MAX_RST;
      max_prediv <= MAX_PRE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RC_OSC:  rc_osc_hz  <= cfg.data[EXT_W-1:0];
        CFG_VCO_MIN: vco_min_hz <= cfg.data[VCO_W-1:0];
        CFG_VCO_MAX: vco_max_hz <= cfg.data[VCO_W-1:0];
        CFG_MAX_PRE: max_prediv <= cfg.data[PREDIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer. Moving to the next pre-divider restarts the multiplier at two; when
  // the pre-divider limit is already reached the search ends without a match.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= (req.target_hz == '0) ? S_FINISH : S_START_Q;
          end
        end
        S_START_Q: state <= S_WAIT_Q;
        S_WAIT_Q: begin
          if (drsp.done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (vco < {1'b0, vco_min_hz}) begin
            if (mult_last) begin
              state <= (prediv >= lim) ? S_FINISH : S_START_Q;
            end
          end else if (vco > {1'b0, vco_max_hz}) begin
            state <= (prediv >= lim) ? S_FINISH : S_START_Q;
          end else begin
            state <= S_START_T;
          end
        end
        S_START_T: state <= S_WAIT_T;
        S_WAIT_T: begin
          if (drsp.done) begin
            if (exact) begin
              state <= S_FINISH;
            end else if (mult_last) begin
              state <= (prediv >= lim) ? S_FINISH : S_START_Q;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          ext    <= req.ext_hz;
          target <= req.target_hz;
          base   <= (req.ext_hz != '0) ? req.ext_hz : rc_osc_hz;
          if (max_prediv == '0) begin
            lim <= PREDIV_W'(1);
          end else if (max_prediv > PREDIV_CAP) begin
            lim <= PREDIV_CAP;
          end else begin
            lim <= max_prediv;
          end
          prediv <= PREDIV_W'(1);
          hit    <= 1'b0;
        end
      end
      S_WAIT_Q: begin
        if (drsp.done) begin
          q     <= drsp.quotient[EXT_W-1:0];
          vco   <= {{(VCO_W - EXT_W){1'b0}}, drsp.quotient[EXT_W-1:0], 1'b0};
          mhalf <= MHALF_W'(1);
        end
      end
      S_SCAN: begin
        if (vco < {1'b0, vco_min_hz}) begin
          if (mult_last) begin
            prediv <= prediv + 1'b1;
          end else begin
            mhalf <= mhalf + 1'b1;
            vco   <= vco_step;
          end
        end else if (vco > {1'b0, vco_max_hz}) begin
          prediv <= prediv + 1'b1;
        end
      end
      S_WAIT_T: begin
        if (drsp.done) begin
          if (exact) begin
            // A post-divider above the encodable limit ends the search unfound.
            hit      <= (drsp.quotient <= POSTDIV_CAP);
            div_code <= drsp.quotient[7:0] - 8'd1;
          end else if (mult_last) begin
            prediv <= prediv + 1'b1;
          end else begin
            mhalf <= mhalf + 1'b1;
            vco   <= vco_step;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_found  <= hit;
      out_main   <= (ext != '0);
      out_high   <= (ext >= RANGE_HIGH_HZ);
      out_prediv <= hit ? 5'(prediv - 1'b1) : 5'd0;
      out_mult   <= hit ? 15'(mhalf - 1'b1) : 15'd0;
      out_div    <= hit ? div_code : 8'd0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_found;
  assign rsp.use_main_osc   = out_main;
  assign rsp.osc_range_high = out_high;
  assign rsp.prediv_code    = out_prediv;
  assign rsp.mult_code      = out_mult;
  assign rsp.cpu_div_code   = out_div;

  `PDS_ASSERT_NEXT(a_req_leaves_idle, req_xfer, state != S_IDLE, "request did not start a search")
  `PDS_ASSERT_NOW(a_div_free, dreq.start, !drsp.busy, "divider started while busy")
  `PDS_ASSERT_NOW(a_prediv_range, state == S_SCAN, prediv != '0 && prediv <= lim,
                  "pre-divider outside its limit")
  `PDS_ASSERT_NEXT(a_finish_loads, state == S_FINISH && out_free, out_valid,
                   "finished search did not load a result")

endmodule

// ===== rtl/pds_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pds_pkg for widths and the request/response structs.
module pds_div import pds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  pds_div_req_t dreq,
  output pds_div_rsp_t drsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       trial;

  assign trial = {rem, quo[DIV_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end else if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && dreq.start) begin
      rem <= '0;
      quo <= dreq.dividend;
      dvs <= dreq.divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign drsp.busy      = busy;
  assign drsp.done      = done;
  assign drsp.quotient  = quo;
  assign drsp.remainder = rem;

endmodule
